>>> hw/rtl/lcgrid_pkg.sv
// Package for the random index draw block: field widths, generator constants,
// configuration register indexes and the sequencer state type.
// No dependencies.
package lcgrid_pkg;

  localparam int STATE_W   = 31;   // generator state bits that matter
  localparam int STEP_W    = 5;    // step counter, counts up to STATE_W - 1
  localparam int RAW_SHIFT = 16;   // raw value starts at this state bit
  localparam int OUT_W     = 15;   // width of index and raw_value results
  localparam int COUNT_W   = 7;    // width of draw_count
  localparam int SEED_W    = 32;
  localparam int MOD_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [STATE_W-1:0] LCG_MUL = 31'(32'd1103515245);
  localparam logic [STATE_W-1:0] LCG_ADD = 31'd12345;

  localparam logic [CFG_IDX_W-1:0] REG_SEED    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } lcgrid_state_t;

endpackage

>>> hw/rtl/lcg_random_index_draw.sv
// Top level of the random index draw block: bit-serial LCG step and a
// bit-serial restoring divider for the modulo reduction.
// Depends on lcgrid_pkg.
//
// Each draw runs the serial multiplier over all STATE_W state bits, then the
// serial divider over the RAW_BITS raw-value bits, then loads the output
// register once the previous result has gone or is being taken. A new request
// is taken only once the previous one has issued its last draw.
// The serial multiplier is the longest of these steps.
// Reset (rst_n low, synchronous) sets the state to 1, seed and modulus to 1,
// and empties the output register.
module lcg_random_index_draw
  import lcgrid_pkg::*;
#(
  parameter int RAW_BITS  = 15,   // 1 to 15
  parameter int MAX_DRAWS = 64    // 1 to 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Request channel.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [6:0] draw_count, [7] zero
  input  logic                 in_tuser,   // [0] reseed
  // Result channel.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,  // [14:0] index, [29:15] raw_value, [31:30] zero
  output logic                 out_tlast,  // last draw of the request
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SEED_W-1:0]    cfg_data
);

  lcgrid_state_t state_r, state_nxt;

  logic [SEED_W-1:0]   seed_r;
  logic [MOD_W-1:0]    modulus_r;
  logic [STATE_W-1:0]  lcg_r, lcg_nxt;        // generator state
  logic [STATE_W-1:0]  acc_r, acc_nxt;        // product accumulator
  logic [STATE_W-1:0]  mcand_r, mcand_nxt;    // multiplier constant, shifted up each step
  logic [STATE_W-1:0]  sh_r, sh_nxt;          // state bits, shifted down each step
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [RAW_BITS-1:0] quo_r, quo_nxt;        // raw value, shifted out MSB first
  logic [MOD_W-1:0]    rem_r, rem_nxt;        // partial remainder
  logic [COUNT_W-1:0]  left_r, left_nxt;      // draws still owed

  logic [OUT_W-1:0]    out_index_r, out_raw_r;
  logic                out_last_r, out_valid_r;

  logic                in_fire, out_load, mul_done, div_done;
  logic [COUNT_W-1:0]  count_sat;
  logic [STATE_W-1:0]  acc_sum;
  logic [MOD_W:0]      trial;
  logic                trial_ge;
  logic [RAW_BITS-1:0] raw_now;
  logic [OUT_W-1:0]    index_now;

  // Accepted request, with the draw count saturated to MAX_DRAWS.
  assign in_fire   = in_tvalid && in_tready;
  assign count_sat = (in_tdata[COUNT_W-1:0] > COUNT_W'(MAX_DRAWS)) ?
                     COUNT_W'(MAX_DRAWS) : in_tdata[COUNT_W-1:0];

  // One shift-add step: the product of the state and the constant builds up
  // from the low bit of the state, starting from the additive constant.
  assign acc_sum  = acc_r + (sh_r[0] ? mcand_r : '0);
  assign mul_done = (step_r == STEP_W'(STATE_W - 1));

  // One restoring division step on the raw value.
  assign trial    = {rem_r, quo_r[RAW_BITS-1]};
  assign trial_ge = (trial >= {1'b0, modulus_r});
  assign div_done = (step_r == STEP_W'(RAW_BITS - 1));

  // A zero modulus means no reduction at all.
  assign raw_now   = lcg_r[RAW_SHIFT +: RAW_BITS];
  assign index_now = (modulus_r == '0) ? OUT_W'(raw_now) : OUT_W'(rem_r[RAW_BITS-1:0]);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire && count_sat != '0) state_nxt = ST_MUL;
      ST_MUL:  if (mul_done) state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_load) state_nxt = (left_r == COUNT_W'(1)) ? ST_IDLE : ST_MUL;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs of the sequencer. The output register is loaded once
  // the previous result has gone or is being taken; until then the sequencer
  // waits in ST_EMIT and takes no new request.
  always_comb begin
    in_tready = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_EMIT: out_load  = !out_valid_r || out_tready;
      default: begin
        in_tready = 1'b0;
        out_load  = 1'b0;
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    lcg_nxt   = lcg_r;
    acc_nxt   = acc_r;
    mcand_nxt = mcand_r;
    sh_nxt    = sh_r;
    step_nxt  = step_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    left_nxt  = left_r;
    // Every draw, the first one of a request included, starts a fresh
    // serial multiply from the current state, or from the seed on a reseed.
    if (in_fire) begin
      lcg_nxt   = in_tuser ? seed_r[STATE_W-1:0] : lcg_r;
      sh_nxt    = lcg_nxt;
      acc_nxt   = LCG_ADD;
      mcand_nxt = LCG_MUL;
      step_nxt  = '0;
      left_nxt  = count_sat;
    end else if (state_r == ST_MUL) begin
      acc_nxt   = acc_sum;
      sh_nxt    = sh_r >> 1;
      mcand_nxt = mcand_r << 1;
      step_nxt  = step_r + STEP_W'(1);
      if (mul_done) begin
        lcg_nxt  = acc_sum;
        quo_nxt  = acc_sum[RAW_SHIFT +: RAW_BITS];
        rem_nxt  = '0;
        step_nxt = '0;
      end
    end else if (state_r == ST_DIV) begin
      rem_nxt  = trial_ge ? MOD_W'(trial - {1'b0, modulus_r}) : MOD_W'(trial);
      quo_nxt  = quo_r << 1;
      step_nxt = step_r + STEP_W'(1);
    end else if (out_load) begin
      left_nxt  = left_r - COUNT_W'(1);
      sh_nxt    = lcg_r;
      acc_nxt   = LCG_ADD;
      mcand_nxt = LCG_MUL;
      step_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seed_r      <= SEED_W'(1);
      modulus_r   <= MOD_W'(1);
      lcg_r       <= STATE_W'(1);
      left_r      <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lcg_r   <= lcg_nxt;
      left_r  <= left_nxt;
      step_r  <= step_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_SEED:    seed_r    <= cfg_data;
          REG_MODULUS: modulus_r <= cfg_data[MOD_W-1:0];
          default: ;
        endcase
      end
      if (out_load)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    sh_r    <= sh_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    if (out_load) begin
      out_index_r <= index_now;
      out_raw_r   <= OUT_W'(raw_now);
      out_last_r  <= (left_r == COUNT_W'(1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_raw_r, out_index_r};
  assign out_tlast  = out_last_r;

  // A request with draws starts the multiplier in the next cycle.
  a_start_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && count_sat != '0) |=> (state_r == ST_MUL))
    else $error("request with draws did not start the multiplier");

  // The last draw of a request returns the sequencer to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && left_r == COUNT_W'(1)) |=> (state_r == ST_IDLE))
    else $error("sequencer not idle after last draw");

  // A reduced index never exceeds the raw value it came from.
  a_index_le_raw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_index_r <= out_raw_r))
    else $error("index larger than raw value");

  // The sequencer is only busy while draws are still owed.
  a_left_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (left_r != '0))
    else $error("sequencer busy with no draws left");

  // The divider step counter stays within RAW_BITS - 1 while dividing.
  a_div_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (step_r <= STEP_W'(RAW_BITS - 1)))
    else $error("divider ran past its step count");

endmodule
